// ----- rtl/ibtr_pkg.sv -----
package ibtr_pkg;

	localparam int VAL_W      = 33;
	localparam int LVL_W      = 6;
	localparam int MAX_LEVELS = 32;

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [LVL_W-1:0] lvl_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic done;
	} sts_t;

	typedef struct packed {
		val_t preorder_rank;
		val_t inorder_rank;
		val_t postorder_rank;
		logic in_range;
	} res_t;

endpackage

// ----- rtl/ibtr_in_if.sv -----
interface ibtr_in_if;
	logic              valid;
	logic              ready;
	ibtr_pkg::val_t    node_value;

	modport source (output valid, output node_value, input ready);
	modport sink   (input valid, input node_value, output ready);
endinterface

// ----- rtl/ibtr_out_if.sv -----
interface ibtr_out_if;
	logic              valid;
	logic              ready;
	ibtr_pkg::val_t    preorder_rank;
	ibtr_pkg::val_t    inorder_rank;
	ibtr_pkg::val_t    postorder_rank;
	logic              in_range;

	modport source (output valid, output preorder_rank, output inorder_rank,
		output postorder_rank, output in_range, input ready);
	modport sink   (input valid, input preorder_rank, input inorder_rank,
		input postorder_rank, input in_range, output ready);
endinterface

// ----- rtl/ibtr_ctrl.sv -----
module ibtr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  ibtr_pkg::sts_t sts,
	output ibtr_pkg::cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		cmd.emit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_RUN: begin
				cmd.step = !sts.done;
				cmd.emit = sts.done && out_free;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				state_q <= ST_RUN;
			end else if (cmd.emit) begin
				state_q <= ST_IDLE;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/ibtr_dp.sv -----
module ibtr_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  ibtr_pkg::lvl_t cfg_wdata,
	input  ibtr_pkg::val_t node_value,
	input  ibtr_pkg::cmd_t cmd,
	output ibtr_pkg::sts_t sts,
	output ibtr_pkg::res_t res
);

	ibtr_pkg::lvl_t lv_q;
	ibtr_pkg::lvl_t lv_sat;
	ibtr_pkg::val_t n;
	ibtr_pkg::val_t x_q;
	ibtr_pkg::val_t cur_q;
	ibtr_pkg::val_t skip_q;
	ibtr_pkg::val_t pre_q;
	ibtr_pkg::val_t post_q;
	ibtr_pkg::val_t half;
	ibtr_pkg::val_t post_fin;
	ibtr_pkg::res_t res_q;
	logic           oor_q;
	logic           root_q;
	logic           go_left;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_q <= '0;
		end else if (cfg_we) begin
			lv_q <= cfg_wdata;
		end
	end

	assign lv_sat = (lv_q > ibtr_pkg::LVL_W'(ibtr_pkg::MAX_LEVELS)) ?
		ibtr_pkg::LVL_W'(ibtr_pkg::MAX_LEVELS) : lv_q;
	assign n        = ibtr_pkg::VAL_W'(1) << lv_sat;
	assign half     = skip_q >> 1;
	assign go_left  = x_q < cur_q;
	assign post_fin = post_q + (skip_q << 1) - ibtr_pkg::VAL_W'(1);

	// The walk stops for an out-of-range value, on reaching the node or after the last level.
	assign sts.done = oor_q || root_q || (cur_q == x_q) ||
		(skip_q == ibtr_pkg::VAL_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= node_value;
			cur_q  <= n;
			skip_q <= n;
			pre_q  <= '0;
			post_q <= '0;
			oor_q  <= (node_value == '0) || (node_value > n);
			root_q <= (node_value == n);
		end else if (cmd.step) begin
			skip_q <= half;
			if (go_left) begin
				cur_q <= cur_q - half;
				pre_q <= pre_q + ibtr_pkg::VAL_W'(1);
			end else begin
				cur_q  <= cur_q + half;
				pre_q  <= pre_q + skip_q;
				post_q <= post_q + skip_q - ibtr_pkg::VAL_W'(1);
			end
		end
		if (cmd.emit) begin
			if (oor_q) begin
				res_q <= '0;
			end else if (root_q) begin
				res_q.preorder_rank  <= ibtr_pkg::VAL_W'(1);
				res_q.inorder_rank   <= x_q;
				res_q.postorder_rank <= x_q;
				res_q.in_range       <= 1'b1;
			end else begin
				res_q.preorder_rank  <= pre_q + ibtr_pkg::VAL_W'(1);
				res_q.inorder_rank   <= x_q;
				res_q.postorder_rank <= post_fin;
				res_q.in_range       <= 1'b1;
			end
		end
	end

	assign res = res_q;

endmodule

// ----- rtl/implicit_bst_traversal_rank.sv -----
// Traversal ranks of a node in the implicit search tree over 1..2^L.
// The tree_levels register (L, values above 32 act as 32) is written through
// cfg_we and cfg_wdata; the user must write it only while the block is idle,
// as the block does not enforce this. Reset sets it to zero. A query word on
// node_ch carries node_value; one result word leaves on rank_ch with the
// preorder, inorder and postorder ranks and the in-range flag. Both channels
// use a valid and ready handshake. After a word is accepted, the descent
// steps down one tree level at a time until it reaches the node or the last
// level is done, then loads the output register once that register is free;
// node_ch is ready again in the cycle the result appears. Out-of-range values
// and the root skip the descent.
// One query is worked on at a time; the descent loop and a stalled output
// register set the rate.
// A result that the receiver stalls waits in the output register while the
// next query is accepted and walked; that query then holds until the
// register is free. Reset empties the output register and returns to idle.
module implicit_bst_traversal_rank (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  ibtr_pkg::lvl_t cfg_wdata,
	ibtr_in_if.sink        node_ch,
	ibtr_out_if.source     rank_ch
);

	ibtr_pkg::cmd_t cmd;
	ibtr_pkg::sts_t sts;
	ibtr_pkg::res_t res;

	ibtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (node_ch.valid),
		.in_ready  (node_ch.ready),
		.out_valid (rank_ch.valid),
		.out_ready (rank_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ibtr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.node_value (node_ch.node_value),
		.cmd        (cmd),
		.sts        (sts),
		.res        (res)
	);

	assign rank_ch.preorder_rank  = res.preorder_rank;
	assign rank_ch.inorder_rank   = res.inorder_rank;
	assign rank_ch.postorder_rank = res.postorder_rank;
	assign rank_ch.in_range       = res.in_range;

	a_step_emit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && cmd.emit))
		else $error("Step and emit issued together.");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!rank_ch.valid || rank_ch.ready))
		else $error("Result written over an undelivered word.");

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !node_ch.ready)
		else $error("Input ready while a query is being walked.");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;

	typedef enum logic [1:0] {
		ENT_QUERY,
		ENT_LEVELS,
		ENT_DRAIN
	} ent_kind_t;

	typedef struct {
		ent_kind_t      kind;
		ibtr_pkg::val_t value;
		bit             gaps;
	} pend_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	ibtr_pkg::lvl_t cfg_wdata;

	ibtr_in_if  node_if ();
	ibtr_out_if rank_if ();

	implicit_bst_traversal_rank u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.node_ch  (node_if),
		.rank_ch  (rank_if)
	);

	pend_t          pending_q[$];
	ibtr_pkg::res_t rank_exp_q[$];
	ibtr_pkg::lvl_t levels_cfg;
	int    outstanding;
	int    results_seen;
	int    settle;
	int    hold_cnt;
	int    hold_taken;
	int    err_count;
	int    query_count;

	always #4 clk = ~clk;

	task automatic report(string what, ibtr_pkg::val_t got, ibtr_pkg::val_t want);
		if (err_count < 50)
			$display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
				results_seen);
		err_count++;
	endtask

	function automatic ibtr_pkg::res_t walk_ranks(ibtr_pkg::lvl_t raw, ibtr_pkg::val_t x);
		int unsigned lv;
		int unsigned d;
		logic [63:0] n, cur, pre, post, half, skip;
		ibtr_pkg::res_t r;
		lv = (raw > ibtr_pkg::MAX_LEVELS) ? ibtr_pkg::MAX_LEVELS : raw;
		n = 64'd1 << lv;
		r = '0;
		if (x == '0 || {31'd0, x} > n)
			return r;
		r.in_range = 1'b1;
		r.inorder_rank = x;
		if ({31'd0, x} == n) begin
			r.preorder_rank = ibtr_pkg::val_t'(1);
			r.postorder_rank = ibtr_pkg::val_t'(n);
			return r;
		end
		cur = n;
		pre = '0;
		post = '0;
		d = 0;
		while (cur != {31'd0, x} && d < lv) begin
			half = 64'd1 << (lv - 1 - d);
			if ({31'd0, x} < cur) begin
				cur = cur - half;
				pre = pre + 1;
			end else begin
				skip = 64'd1 << (lv - d);
				cur = cur + half;
				pre = pre + skip;
				post = post + skip - 1;
			end
			d++;
		end
		post = post + (64'd1 << (lv - d + 1)) - 1;
		r.preorder_rank = ibtr_pkg::val_t'(pre + 1);
		r.postorder_rank = ibtr_pkg::val_t'(post);
		return r;
	endfunction

	function automatic ibtr_pkg::val_t pick_node(ibtr_pkg::lvl_t raw);
		int unsigned lv;
		int unsigned roll;
		logic [63:0] n, r;
		lv = (raw > ibtr_pkg::MAX_LEVELS) ? ibtr_pkg::MAX_LEVELS : raw;
		n = 64'd1 << lv;
		roll = $urandom_range(0, 99);
		r = {$urandom(), $urandom()};
		if (roll < 70)
			return ibtr_pkg::val_t'(r % n + 1);
		if (roll < 82) begin
			case ($urandom_range(0, 2))
				0: return ibtr_pkg::val_t'(n);
				1: return ibtr_pkg::val_t'(n - 1);
				default: return ibtr_pkg::val_t'(n + 1);
			endcase
		end
		return ibtr_pkg::val_t'(r);
	endfunction

	task automatic add_query(ibtr_pkg::val_t v);
		pend_t e;
		e.kind = ENT_QUERY;
		e.value = v;
		e.gaps = !(query_count >= 500 && query_count < 700);
		pending_q.push_back(e);
		query_count++;
	endtask

	task automatic add_entry(ent_kind_t kind, ibtr_pkg::lvl_t l);
		pend_t e;
		e.kind = kind;
		e.value = ibtr_pkg::val_t'(l);
		e.gaps = 1'b1;
		pending_q.push_back(e);
	endtask

	task automatic add_phase(ibtr_pkg::lvl_t l);
		int count;
		count = $urandom_range(78, 90);
		add_entry(ENT_LEVELS, l);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				add_entry(ENT_DRAIN, '0);
			add_query(pick_node(l));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_if.valid <= 1'b0;
			node_if.node_value <= '0;
			cfg_we <= 1'b0;
			cfg_wdata <= '0;
			levels_cfg <= '0;
			settle <= 0;
		end else begin : drive
			logic took;
			logic nxt_valid;
			logic nxt_we;
			took = node_if.valid && node_if.ready;
			nxt_valid = node_if.valid && !took;
			nxt_we = 1'b0;
			if (!nxt_valid && pending_q.size() != 0) begin
				case (pending_q[0].kind)
					ENT_QUERY: begin
						if (!pending_q[0].gaps || $urandom_range(0, 99) >= 28) begin
							nxt_valid = 1'b1;
							node_if.node_value <= pending_q[0].value;
							void'(pending_q.pop_front());
						end
					end
					ENT_LEVELS: begin
						if (settle >= SETTLE_CYCLES) begin
							nxt_we = 1'b1;
							cfg_wdata <= pending_q[0].value[ibtr_pkg::LVL_W-1:0];
							levels_cfg <= pending_q[0].value[ibtr_pkg::LVL_W-1:0];
							void'(pending_q.pop_front());
						end
					end
					ENT_DRAIN: begin
						if (outstanding == 0)
							void'(pending_q.pop_front());
					end
					default: begin
						void'(pending_q.pop_front());
					end
				endcase
			end
			node_if.valid <= nxt_valid;
			cfg_we <= nxt_we;
			settle <= (outstanding == 0 && !node_if.valid) ? settle + 1 : 0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_if.ready <= 1'b0;
			hold_cnt <= 0;
			hold_taken <= 0;
		end else if (hold_cnt != 0) begin
			rank_if.ready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_taken < 2 && results_seen >= (hold_taken == 0 ? 300 : 950)) begin
			rank_if.ready <= 1'b0;
			hold_cnt <= HOLD_CYCLES;
			hold_taken <= hold_taken + 1;
		end else if (results_seen >= 500 && results_seen < 700) begin
			rank_if.ready <= 1'b1;
		end else begin
			rank_if.ready <= ($urandom_range(0, 99) >= 28);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding <= 0;
			results_seen <= 0;
		end else begin : watch
			ibtr_pkg::res_t want;
			logic took_in;
			logic took_out;
			took_in = node_if.valid && node_if.ready;
			took_out = rank_if.valid && rank_if.ready;
			if (took_out) begin
				if (rank_exp_q.size() == 0) begin
					report("unexpected word", rank_if.preorder_rank, '0);
				end else begin
					want = rank_exp_q.pop_front();
					if (rank_if.preorder_rank !== want.preorder_rank)
						report("preorder_rank", rank_if.preorder_rank, want.preorder_rank);
					if (rank_if.inorder_rank !== want.inorder_rank)
						report("inorder_rank", rank_if.inorder_rank, want.inorder_rank);
					if (rank_if.postorder_rank !== want.postorder_rank)
						report("postorder_rank", rank_if.postorder_rank, want.postorder_rank);
					if (rank_if.in_range !== want.in_range)
						report("in_range", ibtr_pkg::val_t'(rank_if.in_range),
							ibtr_pkg::val_t'(want.in_range));
				end
			end
			if (took_in)
				rank_exp_q.push_back(walk_ranks(levels_cfg, node_if.node_value));
			outstanding <= outstanding + int'(took_in) - int'(took_out);
			if (took_out)
				results_seen <= results_seen + 1;
		end
	end

	initial begin
		ibtr_pkg::lvl_t phase_levels[15];
		node_if.valid = 1'b0;
		node_if.node_value = '0;
		rank_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		err_count = 0;
		query_count = 0;
		phase_levels = '{6'd2, 6'd3, 6'd5, 6'd8, 6'd63, 6'd12, 6'd16, 6'd0, 6'd20,
			6'd31, 6'd32, 6'd1, 6'd33, 6'd24, 6'd4};

		add_query(ibtr_pkg::val_t'(0));
		add_query(ibtr_pkg::val_t'(1));
		add_query(ibtr_pkg::val_t'(2));
		add_query({ibtr_pkg::VAL_W{1'b1}});
		add_entry(ENT_LEVELS, 6'd32);
		add_query(ibtr_pkg::val_t'(64'd1 << 32));
		add_query(ibtr_pkg::val_t'((64'd1 << 32) + 1));
		add_query(ibtr_pkg::val_t'(1));
		add_query(ibtr_pkg::val_t'(3));
		add_query(ibtr_pkg::val_t'(64'd1 << 31));
		add_query(ibtr_pkg::val_t'((64'd1 << 32) - 1));
		add_query(33'h0_AAAA_AAAA);
		add_query(33'h1_5555_5555);
		add_query({ibtr_pkg::VAL_W{1'b1}});
		add_entry(ENT_LEVELS, 6'd63);
		add_query(ibtr_pkg::val_t'(64'd1 << 32));
		add_query(ibtr_pkg::val_t'(1));
		add_query(ibtr_pkg::val_t'((64'd1 << 32) - 1));
		add_entry(ENT_LEVELS, 6'd1);
		add_query(ibtr_pkg::val_t'(1));
		add_query(ibtr_pkg::val_t'(2));
		add_query(ibtr_pkg::val_t'(3));
		foreach (phase_levels[i])
			add_phase(phase_levels[i]);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || outstanding != 0 || node_if.valid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (rank_exp_q.size() != 0)
			report("missing words", ibtr_pkg::val_t'(0),
				ibtr_pkg::val_t'(rank_exp_q.size()));
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/ibtr_pkg.sv
rtl/ibtr_in_if.sv
rtl/ibtr_out_if.sv
rtl/ibtr_ctrl.sv
rtl/ibtr_dp.sv
rtl/implicit_bst_traversal_rank.sv
tb/sv/testbench.sv
